/* rtl/core/assert_macros.svh */
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, switched off while reset is high
`define ASSERT_CLK_RST(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// clocked assertion that also holds through reset
`define ASSERT_CLK(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("assertion failed");

`endif

/* rtl/core/dmm_pkg.sv */
`default_nettype none

package dmm_pkg;

   // sizes
   localparam int MAX_DIM_DEFAULT = 8;
   localparam int ELEM_WIDTH      = 16;
   localparam int DIM_W           = 4;
   localparam int CNT_W           = 7;
   localparam int PROD_W          = 35;
   localparam int IDX_OUT_W       = 3;
   localparam int CSR_IDX_W       = 2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ROWS_A    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INNER_DIM = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COLS_C    = 2'd2;

   localparam logic [DIM_W-1:0] DIM_RESET = 4'd8;

   typedef struct packed {
      logic                         func;
      logic signed [ELEM_WIDTH-1:0] element;
   } dmm_req_type;

   typedef struct packed {
      logic signed [PROD_W-1:0] product_value;
      logic [IDX_OUT_W-1:0]     out_row;
      logic [IDX_OUT_W-1:0]     out_col;
      logic                     last;
   } dmm_rsp_type;

   // matrix sizes after clamping
   typedef struct packed {
      logic [DIM_W-1:0] nr;
      logic [DIM_W-1:0] nk;
      logic [DIM_W-1:0] nc;
   } dmm_dims_type;

endpackage

`default_nettype wire

/* rtl/core/dmm_ram.sv */
`default_nettype none

module dmm_ram #(
   parameter int DEPTH  = dmm_pkg::MAX_DIM_DEFAULT * dmm_pkg::MAX_DIM_DEFAULT,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   parameter int DATA_W = dmm_pkg::ELEM_WIDTH
) (
   input  wire logic              clock,
   input  wire logic              we,
   input  wire logic [ADDR_W-1:0] waddr,
   input  wire logic [DATA_W-1:0] wdata,
   input  wire logic              re,
   input  wire logic [ADDR_W-1:0] raddr,
   output logic      [DATA_W-1:0] rdata
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

/* rtl/core/dmm_engine.sv */
`default_nettype none

module dmm_engine #(
   parameter int MAX_DIM = dmm_pkg::MAX_DIM_DEFAULT,
   parameter int DEPTH   = MAX_DIM * MAX_DIM,
   parameter int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire dmm_pkg::dmm_dims_type         dims,
   output logic                               busy,
   output logic                               rd_en,
   output logic [ADDR_W-1:0]                  a_raddr,
   output logic [ADDR_W-1:0]                  b_raddr,
   input  wire logic [dmm_pkg::ELEM_WIDTH-1:0] a_rdata,
   input  wire logic [dmm_pkg::ELEM_WIDTH-1:0] b_rdata,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output dmm_pkg::dmm_rsp_type               rsp_data
);

   import dmm_pkg::*;

   localparam int IDX_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
   localparam int MUL_W = 2 * ELEM_WIDTH;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_READ  = 4'b0010,
      ST_FLUSH = 4'b0100,
      ST_SEND  = 4'b1000
   } dmm_state_type;

   dmm_state_type state_ff, state_in;
   logic [IDX_W-1:0] i_ff, i_in, j_ff, j_in, k_ff, k_in;
   logic rd_vld_ff, rd_vld_in, rd_last_ff, rd_last_in;
   logic mul_vld_ff, mul_vld_in, mul_last_ff, mul_last_in;
   logic done_ff, done_in;
   logic signed [MUL_W-1:0]  prod_ff, prod_in;
   logic signed [PROD_W-1:0] acc_ff, acc_in;
   logic rsp_valid_ff, rsp_valid_in;
   dmm_rsp_type rsp_data_ff, rsp_data_in;

   logic k_last, j_last, i_last, out_free;

   assign k_last   = (DIM_W'(k_ff) == dims.nk - DIM_W'(1));
   assign j_last   = (DIM_W'(j_ff) == dims.nc - DIM_W'(1));
   assign i_last   = (DIM_W'(i_ff) == dims.nr - DIM_W'(1));
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // row-major store addresses
   assign a_raddr = ADDR_W'(CNT_W'(i_ff) * CNT_W'(dims.nk) + CNT_W'(k_ff));
   assign b_raddr = ADDR_W'(CNT_W'(k_ff) * CNT_W'(dims.nc) + CNT_W'(j_ff));

   always_comb begin
      state_in     = state_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      k_in         = k_ff;
      rd_en        = 1'b0;
      rd_vld_in    = 1'b0;
      rd_last_in   = 1'b0;
      mul_vld_in   = rd_vld_ff;
      mul_last_in  = rd_last_ff;
      prod_in      = $signed(a_rdata) * $signed(b_rdata);
      done_in      = done_ff;
      acc_in       = acc_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;

      if (mul_vld_ff) begin
         acc_in = acc_ff + PROD_W'(prod_ff);
         if (mul_last_ff) begin
            done_in = 1'b1;
         end
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               i_in     = '0;
               j_in     = '0;
               k_in     = '0;
               acc_in   = '0;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            rd_en      = 1'b1;
            rd_vld_in  = 1'b1;
            rd_last_in = k_last;
            if (k_last) begin
               k_in     = '0;
               state_in = ST_FLUSH;
            end else begin
               k_in = k_ff + IDX_W'(1);
            end
         end
         ST_FLUSH: begin
            if (done_ff) begin
               done_in  = 1'b0;
               state_in = ST_SEND;
            end
         end
         ST_SEND: begin
            if (out_free) begin
               rsp_valid_in              = 1'b1;
               rsp_data_in.product_value = acc_ff;
               rsp_data_in.out_row       = IDX_OUT_W'(i_ff);
               rsp_data_in.out_col       = IDX_OUT_W'(j_ff);
               rsp_data_in.last          = i_last && j_last;
               acc_in                    = '0;
               if (i_last && j_last) begin
                  state_in = ST_IDLE;
               end else begin
                  if (j_last) begin
                     j_in = '0;
                     i_in = i_ff + IDX_W'(1);
                  end else begin
                     j_in = j_ff + IDX_W'(1);
                  end
                  state_in = ST_READ;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rd_vld_ff    <= 1'b0;
         mul_vld_ff   <= 1'b0;
         done_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rd_vld_ff    <= rd_vld_in;
         mul_vld_ff   <= mul_vld_in;
         done_ff      <= done_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      i_ff        <= i_in;
      j_ff        <= j_in;
      k_ff        <= k_in;
      rd_last_ff  <= rd_last_in;
      mul_last_ff <= mul_last_in;
      prod_ff     <= prod_in;
      acc_ff      <= acc_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

/* rtl/core/dense_matrix_multiply_top.sv */
// Dense matrix multiply C = A x B on signed Q8.8 elements, giving exact signed
// Q19.16 results. Set rows_a, inner_dim and cols_c (register indexes 0, 1, 2;
// 0 acts as 1, above MAX_DIM acts as MAX_DIM) while the block is idle, then
// send A in row-major order (func 0) followed by B in row-major order
// (func 1). The load of the final B element starts a burst of rows_a * cols_c
// results in row-major order, each tagged with its row and column, the final
// one flagged last. During the burst req_stall is high; each C element is
// summed by the single multiply-accumulate unit that reads one A and one B
// entry per cycle while summing, from the two element stores, and a result is
// held while rsp_stall is high. Extra A loads beyond rows_a * inner_dim are
// dropped until the next burst, and A entries not reloaded keep their older
// contents. Store entries never written read back undefined.

`default_nettype none

module dense_matrix_multiply_top #(
   parameter int MAX_DIM = dmm_pkg::MAX_DIM_DEFAULT
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire dmm_pkg::dmm_req_type            req_data,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output dmm_pkg::dmm_rsp_type                 rsp_data,
   input  wire logic                            csr_we,
   input  wire logic [dmm_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [dmm_pkg::DIM_W-1:0]       csr_wdata
);

   import dmm_pkg::*;

   localparam int DEPTH  = MAX_DIM * MAX_DIM;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   // configuration registers, raw as written
   logic [DIM_W-1:0] rows_a_ff, rows_a_in;
   logic [DIM_W-1:0] inner_dim_ff, inner_dim_in;
   logic [DIM_W-1:0] cols_c_ff, cols_c_in;

   // load positions in the two stores
   logic [CNT_W-1:0] a_cnt_ff, a_cnt_in;
   logic [CNT_W-1:0] b_cnt_ff, b_cnt_in;

   dmm_dims_type dims;
   logic [CNT_W-1:0] a_lim, b_lim;
   logic accept, a_load, b_load, a_we, b_we, fire, busy, rd_en;
   logic [ADDR_W-1:0] a_raddr, b_raddr;
   logic [ELEM_WIDTH-1:0] a_rdata, b_rdata;

   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
      logic [DIM_W-1:0] r;
      r = v;
      if (v == '0) begin
         r = DIM_W'(1);
      end else if (v > DIM_W'(MAX_DIM)) begin
         r = DIM_W'(MAX_DIM);
      end
      return r;
   endfunction

   assign dims.nr = clamp_dim(rows_a_ff);
   assign dims.nk = clamp_dim(inner_dim_ff);
   assign dims.nc = clamp_dim(cols_c_ff);

   // number of elements in A and in B
   assign a_lim = CNT_W'(dims.nr) * CNT_W'(dims.nk);
   assign b_lim = CNT_W'(dims.nk) * CNT_W'(dims.nc);

   // loads wait while a burst is being worked out
   assign req_stall = busy;
   assign accept    = req_valid && !req_stall;
   assign a_load    = accept && !req_data.func;
   assign b_load    = accept && req_data.func;
   assign a_we      = a_load && (a_cnt_ff < a_lim);
   assign b_we      = b_load && (b_cnt_ff < b_lim);

   // burst fires on the final B element, or at once if B is already full
   assign fire = b_load && ((b_cnt_ff + CNT_W'(1)) >= b_lim);

   always_comb begin
      rows_a_in    = rows_a_ff;
      inner_dim_in = inner_dim_ff;
      cols_c_in    = cols_c_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_ROWS_A:    rows_a_in    = csr_wdata;
            CSR_INNER_DIM: inner_dim_in = csr_wdata;
            CSR_COLS_C:    cols_c_in    = csr_wdata;
            default:       ;
         endcase
      end
   end

   always_comb begin
      a_cnt_in = a_cnt_ff;
      b_cnt_in = b_cnt_ff;
      if (a_we) begin
         a_cnt_in = a_cnt_ff + CNT_W'(1);
      end
      if (b_we) begin
         b_cnt_in = b_cnt_ff + CNT_W'(1);
      end
      // both counts restart with every burst
      if (fire) begin
         a_cnt_in = '0;
         b_cnt_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_a_ff    <= DIM_RESET;
         inner_dim_ff <= DIM_RESET;
         cols_c_ff    <= DIM_RESET;
         a_cnt_ff     <= '0;
         b_cnt_ff     <= '0;
      end else begin
         rows_a_ff    <= rows_a_in;
         inner_dim_ff <= inner_dim_in;
         cols_c_ff    <= cols_c_in;
         a_cnt_ff     <= a_cnt_in;
         b_cnt_ff     <= b_cnt_in;
      end
   end

   // element store for A
   dmm_ram #(
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W),
      .DATA_W (ELEM_WIDTH)
   ) u_a_ram (
      .clock (clock),
      .we    (a_we),
      .waddr (a_cnt_ff[ADDR_W-1:0]),
      .wdata (req_data.element),
      .re    (rd_en),
      .raddr (a_raddr),
      .rdata (a_rdata)
   );

   // element store for B
   dmm_ram #(
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W),
      .DATA_W (ELEM_WIDTH)
   ) u_b_ram (
      .clock (clock),
      .we    (b_we),
      .waddr (b_cnt_ff[ADDR_W-1:0]),
      .wdata (req_data.element),
      .re    (rd_en),
      .raddr (b_raddr),
      .rdata (b_rdata)
   );

   // sequencer, multiply-accumulate and output register
   dmm_engine #(
      .MAX_DIM (MAX_DIM),
      .DEPTH   (DEPTH),
      .ADDR_W  (ADDR_W)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .start     (fire),
      .dims      (dims),
      .busy      (busy),
      .rd_en     (rd_en),
      .a_raddr   (a_raddr),
      .b_raddr   (b_raddr),
      .a_rdata   (a_rdata),
      .b_rdata   (b_rdata),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

/* rtl/core/dmm_checker.sv */
`default_nettype none

`include "assert_macros.svh"

module dmm_checker (
   input wire logic                 clock,
   input wire logic                 reset,
   input wire logic                 req_stall,
   input wire logic                 rsp_valid,
   input wire logic                 rsp_stall,
   input wire dmm_pkg::dmm_rsp_type rsp_data
);

   import dmm_pkg::*;

   // a stalled item holds
   `ASSERT_CLK_RST(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))

   // a fresh item only comes out of a running burst
   `ASSERT_CLK_RST(a_rsp_from_burst, clock, reset, $rose(rsp_valid) |-> $past(req_stall))

   // loads stay blocked until the last item of a burst is out
   `ASSERT_CLK_RST(a_busy_mid_burst, clock, reset, rsp_valid && !rsp_data.last |-> req_stall)

   // reset leaves the block idle and empty
   `ASSERT_CLK(a_reset_idle, clock, reset |=> !rsp_valid && !req_stall)

endmodule

bind dense_matrix_multiply_top dmm_checker u_dmm_checker (
   .clock     (clock),
   .reset     (reset),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

`default_nettype wire

/* bench/tb_dense_matrix_multiply_top.sv */
`timescale 1ns / 1ps

module tb_dense_matrix_multiply_top;
   import dmm_pkg::*;

   // load selectors carried in the func field
   localparam logic FUNC_LOAD_A = 1'b0;
   localparam logic FUNC_LOAD_B = 1'b1;

   localparam int MAX_DIM       = MAX_DIM_DEFAULT;
   localparam int STORE_DEPTH   = MAX_DIM * MAX_DIM;
   localparam int IDLE_PCT      = 17;      // chance in a hundred that a side idles
   localparam int HOLD_CYCLES   = 300;     // long receiver hold-off
   localparam int SETTLE_CYCLES = 40;      // quiet time after draining, covers load latency
   localparam int RANDOM_LOADS  = 150;
   localparam int CYCLE_LIMIT   = 600000;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   dmm_req_type req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   dmm_rsp_type rsp_data;
   logic                 csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_ROWS_A;
   logic [DIM_W-1:0]     csr_wdata = '0;

   dense_matrix_multiply_top i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // items waiting for the driver, and C elements waiting for the monitor
   dmm_req_type pending_loads[$];
   dmm_rsp_type expected_c[$];

   int  errors = 0;
   int  cycle_count = 0;
   logic calm = 1'b0;      // no idling on either side while set
   logic hold_go = 1'b0;   // arms the long receiver hold-off

   // ------------------------------------------------------------------
   // predictor: own copy of the registers, both element stores and the
   // two fill counters, updated on every accepted item
   // ------------------------------------------------------------------
   logic [DIM_W-1:0] cfg_rows, cfg_inner, cfg_cols;
   logic signed [ELEM_WIDTH-1:0] a_elems [STORE_DEPTH];
   logic signed [ELEM_WIDTH-1:0] b_elems [STORE_DEPTH];
   int a_fill, b_fill;

   // 0 acts as 1, anything above the largest size acts as the largest
   function automatic int fit_dim(input logic [DIM_W-1:0] v);
      if (v == 0) return 1;
      if (v > MAX_DIM) return MAX_DIM;
      return int'(v);
   endfunction

   task automatic predict_load(input dmm_req_type item);
      int nr, nk, nc, i, j, k;
      longint acc;
      dmm_rsp_type c_elem;
      nr = fit_dim(cfg_rows);
      nk = fit_dim(cfg_inner);
      nc = fit_dim(cfg_cols);
      if (item.func == FUNC_LOAD_A) begin
         // a full A store drops further A items until the next burst
         if (a_fill < nr * nk) begin
            a_elems[a_fill] = item.element;
            a_fill++;
         end
      end else begin
         // after the sizes shrink the counter may already be at the limit
         if (b_fill < nk * nc) begin
            b_elems[b_fill] = item.element;
            b_fill++;
         end
         if (b_fill >= nk * nc) begin
            for (i = 0; i < nr; i++) begin
               for (j = 0; j < nc; j++) begin
                  acc = 0;
                  for (k = 0; k < nk; k++)
                     acc += longint'(a_elems[i * nk + k]) * longint'(b_elems[k * nc + j]);
                  c_elem.product_value = acc[PROD_W-1:0];
                  c_elem.out_row       = IDX_OUT_W'(i);
                  c_elem.out_col       = IDX_OUT_W'(j);
                  c_elem.last          = (i == nr - 1) && (j == nc - 1);
                  expected_c.push_back(c_elem);
               end
            end
            a_fill = 0;
            b_fill = 0;
         end
      end
   endtask

   // ------------------------------------------------------------------
   // driver: offers the next pending item, holds it until accepted, and
   // mirrors register writes into the predictor at the edge the block sees them
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         cfg_rows  = DIM_RESET;
         cfg_inner = DIM_RESET;
         cfg_cols  = DIM_RESET;
         a_fill    = 0;
         b_fill    = 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_ROWS_A:    cfg_rows  = csr_wdata;
               CSR_INNER_DIM: cfg_inner = csr_wdata;
               CSR_COLS_C:    cfg_cols  = csr_wdata;
               default: ;
            endcase
         end
         if (req_valid && !req_stall)
            predict_load(req_data);
         // a stalled item stays put; otherwise offer the next or idle
         if (!req_valid || !req_stall) begin
            if (pending_loads.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
               req_valid <= 1'b1;
               req_data  <= pending_loads.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // receiver stall: random idling, plus one long hold-off counted here
   // once armed, started by the first result seen after arming
   // ------------------------------------------------------------------
   int   hold_left;
   logic hold_done;

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_left <= 0;
         hold_done <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else if (hold_go && !hold_done && rsp_valid) begin
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
      end
   end

   // ------------------------------------------------------------------
   // monitor: every accepted result against the oldest expected C element
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      dmm_rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_c.size() == 0) begin
            errors++;
            $display("%0t: unexpected result, expected none, got value %0d row %0d col %0d last %0d",
                     $time, rsp_data.product_value, rsp_data.out_row, rsp_data.out_col,
                     rsp_data.last);
         end else begin
            want = expected_c.pop_front();
            if (rsp_data.product_value !== want.product_value) begin
               errors++;
               $display("%0t: product_value at C[%0d][%0d] expected %0d, got %0d", $time,
                        want.out_row, want.out_col, want.product_value, rsp_data.product_value);
            end
            if (rsp_data.out_row !== want.out_row) begin
               errors++;
               $display("%0t: out_row expected %0d, got %0d", $time, want.out_row,
                        rsp_data.out_row);
            end
            if (rsp_data.out_col !== want.out_col) begin
               errors++;
               $display("%0t: out_col expected %0d, got %0d", $time, want.out_col,
                        rsp_data.out_col);
            end
            if (rsp_data.last !== want.last) begin
               errors++;
               $display("%0t: last at C[%0d][%0d] expected %0d, got %0d", $time,
                        want.out_row, want.out_col, want.last, rsp_data.last);
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb_dense_matrix_multiply_top: FAIL");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // stimulus bookkeeping: fill counters as the stimulus sees them, and how
   // far into the A store has ever been written, so that no burst reads
   // an A entry that was never loaded
   // ------------------------------------------------------------------
   int gen_nr = MAX_DIM, gen_nk = MAX_DIM, gen_nc = MAX_DIM;
   int gen_a_fill = 0, gen_b_fill = 0, gen_a_reach = 0;
   int load_count = 0;   // items that change state; dropped A items not counted

   function automatic logic signed [ELEM_WIDTH-1:0] rand_elem();
      case ($urandom_range(9))
         0:       return 16'sh7fff;
         1:       return 16'sh8000;
         2:       return 16'sh0000;
         default: return ELEM_WIDTH'($urandom());
      endcase
   endfunction

   task automatic queue_item(input logic func, input logic signed [ELEM_WIDTH-1:0] elem);
      dmm_req_type item;
      item.func    = func;
      item.element = elem;
      if (func == FUNC_LOAD_A) begin
         if (gen_a_fill < gen_nr * gen_nk) begin
            gen_a_fill++;
            if (gen_a_fill > gen_a_reach) gen_a_reach = gen_a_fill;
            load_count++;
         end
      end else begin
         load_count++;
         if (gen_b_fill < gen_nk * gen_nc) gen_b_fill++;
         if (gen_b_fill >= gen_nk * gen_nc) begin
            gen_a_fill = 0;
            gen_b_fill = 0;
         end
      end
      pending_loads.push_back(item);
   endtask

   // a B item that completes B first tops up A if part of it was never written
   task automatic queue_b(input logic signed [ELEM_WIDTH-1:0] elem);
      if (gen_b_fill + 1 >= gen_nk * gen_nc)
         while (gen_a_reach < gen_nr * gen_nk) queue_item(FUNC_LOAD_A, rand_elem());
      queue_item(FUNC_LOAD_B, elem);
   endtask

   // sender pause until every expected result is in and the block has settled
   task automatic wait_drained();
      do @(negedge clock);
      while (pending_loads.size() != 0 || req_valid || expected_c.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // sizes are only changed with the block idle
   task automatic write_dims(input logic [DIM_W-1:0] rows, inner, cols);
      wait_drained();
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= CSR_ROWS_A;
      csr_wdata <= rows;
      @(posedge clock);
      csr_index <= CSR_INNER_DIM;
      csr_wdata <= inner;
      @(posedge clock);
      csr_index <= CSR_COLS_C;
      csr_wdata <= cols;
      @(posedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
      gen_nr = fit_dim(rows);
      gen_nk = fit_dim(inner);
      gen_nc = fit_dim(cols);
   endtask

   // mostly small sizes, now and then a raw 0 or a value above the maximum
   function automatic logic [DIM_W-1:0] pick_dim();
      case ($urandom_range(19))
         0:       return '0;
         1:       return DIM_W'($urandom_range(9, 15));
         2:       return DIM_W'($urandom_range(4, 8));
         default: return DIM_W'($urandom_range(1, 3));
      endcase
   endfunction

   // one set of loads: usually all of A then all of B, sometimes a partial A
   // (burst on older A entries), a surplus A item, stray A items among the
   // B items, or a B that stops short and carries over to the next sizes
   task automatic run_set();
      int roll, n_a, n_b, b_room;
      roll = $urandom_range(99);
      if (roll < 80) n_a = gen_nr * gen_nk - gen_a_fill;
      else n_a = $urandom_range(0, gen_nr * gen_nk);
      repeat (n_a) queue_item(FUNC_LOAD_A, rand_elem());
      if ($urandom_range(3) == 0) queue_item(FUNC_LOAD_A, rand_elem());
      b_room = gen_nk * gen_nc - gen_b_fill;
      if (roll >= 95 && b_room > 1) n_b = $urandom_range(0, b_room - 1);
      else n_b = (b_room < 1) ? 1 : b_room;
      repeat (n_b) begin
         if (roll < 95 && $urandom_range(19) == 0) queue_item(FUNC_LOAD_A, rand_elem());
         // any B item that ends up completing B tops up A first
         queue_b(rand_elem());
      end
   endtask

   // ------------------------------------------------------------------
   // test sequence
   // ------------------------------------------------------------------
   initial begin
      int phase;
      int sets;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // all sizes 0, acting as 1 x 1 x 1: extreme element products
      write_dims(4'd0, 4'd0, 4'd0);
      queue_item(FUNC_LOAD_A, 16'sh7fff);
      queue_b(16'sh7fff);
      queue_item(FUNC_LOAD_A, 16'sh8000);
      queue_item(FUNC_LOAD_A, 16'sh0005);   // surplus A item, dropped
      queue_b(16'sh8000);
      queue_item(FUNC_LOAD_A, 16'sh7fff);
      queue_b(16'sh8000);

      // rows above the maximum act as 8: eight rows of one column
      write_dims(4'd15, 4'd1, 4'd1);
      queue_item(FUNC_LOAD_A, 16'sh7fff);
      queue_item(FUNC_LOAD_A, 16'sh8000);
      queue_item(FUNC_LOAD_A, 16'sh0001);
      queue_item(FUNC_LOAD_A, 16'shffff);
      queue_item(FUNC_LOAD_A, 16'sh0000);
      queue_item(FUNC_LOAD_A, 16'sh0100);
      queue_item(FUNC_LOAD_A, 16'shff00);
      queue_item(FUNC_LOAD_A, 16'sh3039);
      queue_b(16'sh8000);

      // burst with A only partly reloaded: rows 3 to 7 keep older values
      queue_item(FUNC_LOAD_A, 16'sh1234);
      queue_item(FUNC_LOAD_A, 16'shedcb);
      queue_item(FUNC_LOAD_A, 16'sh7fff);
      queue_b(16'sh7fff);

      // B half loaded, then the sizes shrink below the B count:
      // the next B item is dropped and the burst fires at once
      write_dims(4'd1, 4'd2, 4'd2);
      queue_item(FUNC_LOAD_B, 16'sh0203);
      queue_item(FUNC_LOAD_B, 16'shfdfc);
      write_dims(4'd1, 4'd2, 4'd1);
      queue_b(16'sh4000);

      // random part; the long hold-off and the calm stretch always run
      load_count = 0;
      phase = 0;
      while (load_count < RANDOM_LOADS || phase < 4) begin
         if (phase == 1) write_dims(4'd8, 4'd1, 4'd8);   // widest burst
         else write_dims(pick_dim(), pick_dim(), pick_dim());
         calm = (phase == 3);
         if (phase == 1) hold_go = 1'b1;
         sets = (phase == 1 || phase == 3) ? 3 : $urandom_range(1, 3);
         repeat (sets) begin
            if ($urandom_range(4) == 0) wait_drained();
            run_set();
         end
         phase++;
      end

      wait_drained();
      if (errors == 0)
         $display("tb_dense_matrix_multiply_top: PASS");
      else
         $display("tb_dense_matrix_multiply_top: FAIL");
      $finish;
   end

endmodule
